// File: rtl/hcpl_pkg.sv
`default_nettype none
package hcpl_pkg;
   localparam int GROUP_W     = 4;
   localparam int NUM_GROUPS  = 16;
   localparam int ENTRY_W     = 10;
   localparam int CNT_W       = ENTRY_W + 1;
   localparam int MAX_ENTRIES = 1 << ENTRY_W;
   localparam int ADDR_W      = GROUP_W + ENTRY_W;
   localparam int DEPTH       = 1 << ADDR_W;
   localparam int LEN_W       = 32;
   localparam int CUM_W       = 48;
   localparam int FRAC_W      = 16;
   localparam int POS_W       = 6;
   localparam int LOG_W       = POS_W + FRAC_W;
   localparam int MANT_W      = 31;
   localparam int SCALE_W     = 26;
   localparam int PROD_W      = LOG_W + SCALE_W;
   localparam logic [SCALE_W-1:0] TEN_LOG10_2_Q24 = SCALE_W'(50504453);
   localparam logic [PROD_W-1:0]  ROUND_HALF = PROD_W'(1) << (FRAC_W + 23);
   localparam int Q_SHIFT     = FRAC_W + 24;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [11:0] {
      S_IDLE   = 12'b000000000001,
      S_LD_RD  = 12'b000000000010,
      S_LD_WR  = 12'b000000000100,
      S_Q_TOT  = 12'b000000001000,
      S_Q_CHK  = 12'b000000010000,
      S_Q_SRCH = 12'b000000100000,
      S_Q_CMP  = 12'b000001000000,
      S_Q_NORM = 12'b000010000000,
      S_Q_SQ   = 12'b000100000000,
      S_Q_MUL  = 12'b001000000000,
      S_Q_RND  = 12'b010000000000,
      S_OUT    = 12'b100000000000
   } state_type;
endpackage
`default_nettype wire

// File: rtl/histogram_cdf_phred_lookup_unit.sv
`default_nettype none
// Load: count check, previous cumulative read, then store write;
// a load into a full group is dropped at the count check.
// Query: not-found on an empty group or a zero total; else up to 11 binary-search steps,
// then two log2 passes of normalize shifts and 16 squarings each.
// One item in flight; a finished query holds the block in S_OUT while the output is stalled.
// Synchronous reset clears the group counters and control; the stores hold no reset.
module histogram_cdf_phred_lookup_unit (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire                        req_opcode,
   input  wire [hcpl_pkg::GROUP_W-1:0] req_group,
   input  wire                        req_new_group,
   input  wire [hcpl_pkg::LEN_W-1:0]  req_frag_len,
   input  wire [hcpl_pkg::LEN_W-1:0]  req_frequency,
   input  wire [hcpl_pkg::LEN_W-1:0]  req_median,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic                       rsp_found,
   output logic [7:0]                 rsp_quality
);
   import hcpl_pkg::*;

   state_type state_ff, state_in;
   logic [GROUP_W-1:0] g_ff, g_in;
   logic [LEN_W-1:0] len_ff, len_in, freq_ff, freq_in, med_ff, med_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [ENTRY_W-1:0] mid_ff, mid_in;
   logic [CUM_W-1:0] total_ff, total_in, num_ff, num_in, x_ff, x_in;
   logic [POS_W-1:0] p_ff, p_in;
   logic [MANT_W-1:0] m_ff, m_in;
   logic [FRAC_W-1:0] frac_ff, frac_in;
   logic [3:0] iter_ff, iter_in;
   logic second_ff, second_in;
   logic [LOG_W-1:0] lt_ff, lt_in, ln_ff, ln_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic res_found_ff, res_found_in;
   logic [7:0] res_q_ff, res_q_in;
   logic rsp_valid_ff, rsp_valid_in, rsp_found_ff, rsp_found_in;
   logic [7:0] rsp_quality_ff, rsp_quality_in;
   logic [CNT_W-1:0] gc_ff [NUM_GROUPS];
   logic [CNT_W-1:0] gc_in [NUM_GROUPS];

   logic [LEN_W-1:0] len_mem [DEPTH];
   logic [CUM_W-1:0] cum_mem [DEPTH];
   logic [LEN_W-1:0] len_rd_ff;
   logic [CUM_W-1:0] cum_rd_ff;
   logic [ADDR_W-1:0] rd_addr;
   logic wr_en;
   logic [CUM_W-1:0] wr_cum;

   logic [CNT_W-1:0] cnt_eff;
   logic [CNT_W:0] lohi_sum;
   logic [CUM_W-1:0] num_sel;
   logic [MANT_W-1:0] mul_a, mul_b;
   logic [2*MANT_W-1:0] sq;
   logic [MANT_W:0] sq_top;
   logic [FRAC_W-1:0] frac_next;
   logic [LOG_W-1:0] diff;
   logic [PROD_W:0] rnd_sum;
   logic [8:0] q_full;

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_found   = rsp_found_ff;
   assign rsp_quality = rsp_quality_ff;

   assign lohi_sum  = {1'b0, lo_ff} + {1'b0, hi_ff};
   // one multiplier: squarings of the mantissa, then the final scaling
   assign mul_a     = (state_ff == S_Q_MUL) ? {{(MANT_W-LOG_W){1'b0}}, diff} : m_ff;
   assign mul_b     = (state_ff == S_Q_MUL) ?
                      {{(MANT_W-SCALE_W){1'b0}}, TEN_LOG10_2_Q24} : m_ff;
   assign sq        = {{MANT_W{1'b0}}, mul_a} * {{MANT_W{1'b0}}, mul_b};
   assign sq_top    = sq[2*MANT_W-1:MANT_W-1];
   assign frac_next = {frac_ff[FRAC_W-2:0], sq_top[MANT_W]};
   assign diff      = (lt_ff > ln_ff) ? lt_ff - ln_ff : '0;
   assign rnd_sum   = {1'b0, prod_ff} + {1'b0, ROUND_HALF};
   assign q_full    = rnd_sum[PROD_W:Q_SHIFT];
   assign wr_cum    = ((cnt_ff == '0) ? '0 : cum_rd_ff) + {{(CUM_W-LEN_W){1'b0}}, freq_ff};

   always_comb begin
      if (len_ff > med_ff) begin
         num_sel = (total_ff >= cum_rd_ff) ? total_ff - cum_rd_ff : '0;
      end else begin
         num_sel = (cum_rd_ff > total_ff) ? total_ff : cum_rd_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      g_in = g_ff; len_in = len_ff; freq_in = freq_ff; med_in = med_ff;
      cnt_in = cnt_ff; lo_in = lo_ff; hi_in = hi_ff; mid_in = mid_ff;
      total_in = total_ff; num_in = num_ff; x_in = x_ff; p_in = p_ff;
      m_in = m_ff; frac_in = frac_ff; iter_in = iter_ff; second_in = second_ff;
      lt_in = lt_ff; ln_in = ln_ff; prod_in = prod_ff;
      res_found_in = res_found_ff; res_q_in = res_q_ff;
      rsp_valid_in = rsp_valid_ff; rsp_found_in = rsp_found_ff;
      rsp_quality_in = rsp_quality_ff;
      gc_in = gc_ff;
      rd_addr = {g_ff, mid_ff};
      wr_en = 1'b0;
      cnt_eff = req_new_group ? '0 : gc_ff[req_group];
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            g_in = req_group; len_in = req_frag_len;
            freq_in = req_frequency; med_in = req_median;
            if (req_valid) begin
               if (req_opcode == OP_LOAD) begin
                  if (req_new_group) begin
                     gc_in[req_group] = '0;
                  end
                  cnt_in = cnt_eff;
                  if (cnt_eff < CNT_W'(MAX_ENTRIES)) begin
                     state_in = S_LD_RD;
                  end
               end else begin
                  cnt_in = gc_ff[req_group];
                  lo_in  = '0;
                  hi_in  = gc_ff[req_group];
                  if (gc_ff[req_group] == '0) begin
                     res_found_in = 1'b0; res_q_in = '0;
                     state_in = S_OUT;
                  end else begin
                     state_in = S_Q_TOT;
                  end
               end
            end
         end
         S_LD_RD: begin
            rd_addr  = {g_ff, cnt_ff[ENTRY_W-1:0] - ENTRY_W'(1)};
            state_in = S_LD_WR;
         end
         S_LD_WR: begin
            rd_addr  = {g_ff, cnt_ff[ENTRY_W-1:0]};
            wr_en    = 1'b1;
            gc_in[g_ff] = cnt_ff + CNT_W'(1);
            state_in = S_IDLE;
         end
         S_Q_TOT: begin
            rd_addr  = {g_ff, cnt_ff[ENTRY_W-1:0] - ENTRY_W'(1)};
            state_in = S_Q_CHK;
         end
         S_Q_CHK: begin
            total_in = cum_rd_ff;
            if (cum_rd_ff == '0) begin
               res_found_in = 1'b0; res_q_in = '0;
               state_in = S_OUT;
            end else begin
               state_in = S_Q_SRCH;
            end
         end
         S_Q_SRCH: begin
            mid_in  = lohi_sum[ENTRY_W:1];
            rd_addr = {g_ff, lohi_sum[ENTRY_W:1]};
            if (lo_ff < hi_ff) begin
               state_in = S_Q_CMP;
            end else begin
               res_found_in = 1'b0; res_q_in = '0;
               state_in = S_OUT;
            end
         end
         S_Q_CMP: begin
            if (len_rd_ff == len_ff) begin
               num_in = num_sel;
               if (num_sel == '0) begin
                  res_found_in = 1'b1; res_q_in = 8'd255;
                  state_in = S_OUT;
               end else begin
                  x_in = total_ff; p_in = POS_W'(CUM_W - 1);
                  second_in = 1'b0;
                  state_in = S_Q_NORM;
               end
            end else if (len_rd_ff < len_ff) begin
               lo_in = {1'b0, mid_ff} + CNT_W'(1);
               state_in = S_Q_SRCH;
            end else begin
               hi_in = {1'b0, mid_ff};
               state_in = S_Q_SRCH;
            end
         end
         S_Q_NORM: begin
            // shift the top set bit up to the MSB, eight places at a time when possible
            if (x_ff[CUM_W-1:CUM_W-8] == '0) begin
               x_in = x_ff << 8; p_in = p_ff - POS_W'(8);
            end else if (!x_ff[CUM_W-1]) begin
               x_in = x_ff << 1; p_in = p_ff - POS_W'(1);
            end else begin
               m_in = x_ff[CUM_W-1:CUM_W-MANT_W];
               frac_in = '0; iter_in = '0;
               state_in = S_Q_SQ;
            end
         end
         S_Q_SQ: begin
            m_in    = sq_top[MANT_W] ? sq_top[MANT_W:1] : sq_top[MANT_W-1:0];
            frac_in = frac_next;
            iter_in = iter_ff + 4'd1;
            if (iter_ff == 4'(FRAC_W - 1)) begin
               if (!second_ff) begin
                  lt_in = {p_ff, frac_next};
                  x_in = num_ff; p_in = POS_W'(CUM_W - 1);
                  second_in = 1'b1;
                  state_in = S_Q_NORM;
               end else begin
                  ln_in = {p_ff, frac_next};
                  state_in = S_Q_MUL;
               end
            end
         end
         S_Q_MUL: begin
            prod_in  = sq[PROD_W-1:0];
            state_in = S_Q_RND;
         end
         S_Q_RND: begin
            res_found_in = 1'b1;
            res_q_in = q_full[8] ? 8'd255 : q_full[7:0];
            state_in = S_OUT;
         end
         S_OUT: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_quality_in = res_q_ff;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_GROUPS; i++) begin
            gc_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         gc_ff <= gc_in;
      end
      g_ff <= g_in; len_ff <= len_in; freq_ff <= freq_in; med_ff <= med_in;
      cnt_ff <= cnt_in; lo_ff <= lo_in; hi_ff <= hi_in; mid_ff <= mid_in;
      total_ff <= total_in; num_ff <= num_in; x_ff <= x_in; p_ff <= p_in;
      m_ff <= m_in; frac_ff <= frac_in; iter_ff <= iter_in; second_ff <= second_in;
      lt_ff <= lt_in; ln_ff <= ln_in; prod_ff <= prod_in;
      res_found_ff <= res_found_in; res_q_ff <= res_q_in;
      rsp_found_ff <= rsp_found_in; rsp_quality_ff <= rsp_quality_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         len_mem[rd_addr] <= len_ff;
         cum_mem[rd_addr] <= wr_cum;
      end
      len_rd_ff <= len_mem[rd_addr];
      cum_rd_ff <= cum_mem[rd_addr];
   end
endmodule
`default_nettype wire
